@@ hw/rtl/scoped_symbol_slot_resolver_assert.svh @@
// ----------------------------------------------------------------------------
// Scoped symbol slot resolver assertion macros
// Shared concurrent assertion forms used by the interface checker.
// ----------------------------------------------------------------------------
`ifndef SCOPED_SYMBOL_SLOT_RESOLVER_ASSERT_SVH
`define SCOPED_SYMBOL_SLOT_RESOLVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SSR_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SSR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol slot resolver package
// Request and status codes, default sizes, FSM states and the control
// structs exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int ENTRIES_DEF     = 256;
   localparam int FRAMES_DEF      = 16;
   localparam int MAX_DEPTH_DEF   = 15;
   localparam int SYMBOL_BITS_DEF = 16;

   localparam int REQ_W    = 3;
   localparam int SLOT_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 3;

   localparam logic [REQ_W-1:0] OP_ADD    = 3'd0;
   localparam logic [REQ_W-1:0] OP_OPEN   = 3'd1;
   localparam logic [REQ_W-1:0] OP_CLOSE  = 3'd2;
   localparam logic [REQ_W-1:0] OP_PUSH   = 3'd3;
   localparam logic [REQ_W-1:0] OP_POP    = 3'd4;
   localparam logic [REQ_W-1:0] OP_LOOKUP = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_STORE_FULL  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_STACK_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_DEPTH_LIMIT = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_UNDERFLOW   = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_TRIM,
      S_POP_LOAD,
      S_SCAN_LOC,
      S_SCAN_GLB,
      S_ADD_WRITE,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic                latch;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                open_scope;
      logic                trim_start;
      logic                push_frame;
      logic                pop_frame;
      logic                pop_load;
      logic                scan_start;
      logic                scan_global;
      logic                add_write;
   } cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] op;
      logic             depth_max;
      logic             depth_zero;
      logic             store_full;
      logic             stack_full;
      logic             top_zero;
      logic             scan_done;
      logic             trim_done;
      logic             local_hit;
   } stat_type;

endpackage

@@ hw/rtl/scoped_symbol_slot_resolver.sv @@
// A lookup's or add's result beat follows a scan of the current frame's declarations; a local
// miss outside the global frame adds a scan of the global declarations, and a close first
// trims the declarations of the closing scope. One request at a time: busy stays high through
// the result beat, and the store scan, one entry per cycle through a single read port, sets
// the pace. No receiver stall. Synchronous reset leaves one empty global frame.
// ----------------------------------------------------------------------------
// Scoped symbol slot resolver
// Stack of call frames over one declaration store with scope depths and
// newest-first symbol lookup.
// ----------------------------------------------------------------------------
module scoped_symbol_slot_resolver #(
   parameter int ENTRIES     = ssr_pkg::ENTRIES_DEF,
   parameter int FRAMES      = ssr_pkg::FRAMES_DEF,
   parameter int MAX_DEPTH   = ssr_pkg::MAX_DEPTH_DEF,
   parameter int SYMBOL_BITS = ssr_pkg::SYMBOL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ssr_pkg::REQ_W-1:0]    req_type,
   input  logic [SYMBOL_BITS-1:0]       req_symbol_key,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic                         rsp_is_local,
   output logic [ssr_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic                         rsp_in_current_scope,
   output logic [ssr_pkg::COUNT_W-1:0]  rsp_scope_count,
   output logic [ssr_pkg::STATUS_W-1:0] rsp_status
);

   // The controller owns sequencing only. It decides from the datapath's
   // status which actions a request needs (error checks, frame updates,
   // trimming on scope close, the local and global scans) and raises the
   // result strobe for exactly one cycle at the end.
   ssr_pkg::cmd_type  cmd;
   ssr_pkg::stat_type stat;

   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath keeps the declaration store and the saved frame records
   // in RAM. The current frame's base and depth, the total count and the end
   // of the global frame live in registers, so a push saves the current
   // frame record and a pop reads the previous one back in a separate restore state.
   // Every request ends with a scan of the current frame that recounts the
   // declarations at the current depth; for add and lookup the same scan
   // finds whether the key is declared at that depth and the newest match.
   ssr_datapath #(
      .ENTRIES     (ENTRIES),
      .FRAMES      (FRAMES),
      .MAX_DEPTH   (MAX_DEPTH),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_type             (req_type),
      .req_symbol_key       (req_symbol_key),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_found            (rsp_found),
      .rsp_is_local         (rsp_is_local),
      .rsp_slot_index       (rsp_slot_index),
      .rsp_in_current_scope (rsp_in_current_scope),
      .rsp_scope_count      (rsp_scope_count),
      .rsp_status           (rsp_status)
   );

endmodule

@@ hw/rtl/ssr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/ssr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol slot resolver controller
// Sequences each request through decode, trim, frame restore, scans, the
// add write and the single result beat.
// ----------------------------------------------------------------------------
module ssr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   input  ssr_pkg::stat_type stat,
   output ssr_pkg::cmd_type  cmd
);

   ssr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssr_pkg::S_IDLE: begin
            if (start) state_in = ssr_pkg::S_DECODE;
         end
         ssr_pkg::S_DECODE: begin
            if (stat.op == ssr_pkg::OP_CLOSE && !stat.depth_zero) begin
               state_in = ssr_pkg::S_TRIM;
            end else if (stat.op == ssr_pkg::OP_POP && !stat.top_zero) begin
               state_in = ssr_pkg::S_POP_LOAD;
            end else begin
               state_in = ssr_pkg::S_SCAN_LOC;
            end
         end
         ssr_pkg::S_TRIM: begin
            if (stat.trim_done) state_in = ssr_pkg::S_SCAN_LOC;
         end
         ssr_pkg::S_POP_LOAD: begin
            state_in = ssr_pkg::S_SCAN_LOC;
         end
         ssr_pkg::S_SCAN_LOC: begin
            if (stat.scan_done) begin
               if (stat.op == ssr_pkg::OP_LOOKUP && !stat.local_hit && !stat.top_zero) begin
                  state_in = ssr_pkg::S_SCAN_GLB;
               end else if (stat.op == ssr_pkg::OP_ADD && !stat.store_full) begin
                  state_in = ssr_pkg::S_ADD_WRITE;
               end else begin
                  state_in = ssr_pkg::S_RESPOND;
               end
            end
         end
         ssr_pkg::S_SCAN_GLB: begin
            if (stat.scan_done) state_in = ssr_pkg::S_RESPOND;
         end
         ssr_pkg::S_ADD_WRITE: begin
            state_in = ssr_pkg::S_RESPOND;
         end
         ssr_pkg::S_RESPOND: begin
            state_in = ssr_pkg::S_IDLE;
         end
         default: begin
            state_in = ssr_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ssr_pkg::S_IDLE: begin
            cmd.latch = start;
         end
         ssr_pkg::S_DECODE: begin
            cmd.scan_start = 1'b1;
            unique case (stat.op)
               ssr_pkg::OP_ADD: begin
                  if (stat.store_full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ssr_pkg::STAT_STORE_FULL;
                  end
               end
               ssr_pkg::OP_OPEN: begin
                  if (stat.depth_max) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ssr_pkg::STAT_DEPTH_LIMIT;
                  end else begin
                     cmd.open_scope = 1'b1;
                  end
               end
               ssr_pkg::OP_CLOSE: begin
                  if (stat.depth_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ssr_pkg::STAT_UNDERFLOW;
                  end else begin
                     cmd.trim_start = 1'b1;
                     cmd.scan_start = 1'b0;
                  end
               end
               ssr_pkg::OP_PUSH: begin
                  if (stat.stack_full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ssr_pkg::STAT_STACK_FULL;
                  end else begin
                     cmd.push_frame = 1'b1;
                  end
               end
               ssr_pkg::OP_POP: begin
                  if (stat.top_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ssr_pkg::STAT_UNDERFLOW;
                  end else begin
                     cmd.pop_frame  = 1'b1;
                     cmd.scan_start = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         ssr_pkg::S_TRIM: begin
            cmd.scan_start = stat.trim_done;
         end
         ssr_pkg::S_POP_LOAD: begin
            cmd.pop_load   = 1'b1;
            cmd.scan_start = 1'b1;
         end
         ssr_pkg::S_SCAN_LOC: begin
            if (stat.scan_done && stat.op == ssr_pkg::OP_LOOKUP && !stat.local_hit &&
                !stat.top_zero) begin
               cmd.scan_start  = 1'b1;
               cmd.scan_global = 1'b1;
            end
         end
         ssr_pkg::S_ADD_WRITE: begin
            cmd.add_write = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign busy      = (state_ff != ssr_pkg::S_IDLE);
   assign rsp_valid = (state_ff == ssr_pkg::S_RESPOND);

endmodule

@@ hw/rtl/ssr_datapath.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol slot resolver datapath
// Declaration store, saved frame store, frame registers, trim and scan
// engines, and the result registers.
// ----------------------------------------------------------------------------
module ssr_datapath #(
   parameter int ENTRIES     = ssr_pkg::ENTRIES_DEF,
   parameter int FRAMES      = ssr_pkg::FRAMES_DEF,
   parameter int MAX_DEPTH   = ssr_pkg::MAX_DEPTH_DEF,
   parameter int SYMBOL_BITS = ssr_pkg::SYMBOL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ssr_pkg::REQ_W-1:0]    req_type,
   input  logic [SYMBOL_BITS-1:0]       req_symbol_key,
   input  ssr_pkg::cmd_type             cmd,
   output ssr_pkg::stat_type            stat,
   output logic                         rsp_found,
   output logic                         rsp_is_local,
   output logic [ssr_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic                         rsp_in_current_scope,
   output logic [ssr_pkg::COUNT_W-1:0]  rsp_scope_count,
   output logic [ssr_pkg::STATUS_W-1:0] rsp_status
);

   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int FRAME_W = $clog2(FRAMES);
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam int ENTRY_W = SYMBOL_BITS + DEPTH_W;
   localparam int FREC_W  = CNT_W + DEPTH_W;

   localparam logic [CNT_W-1:0]   ENTRIES_C  = CNT_W'(ENTRIES);
   localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAMES - 1);
   localparam logic [DEPTH_W-1:0] DEPTH_LIM  = DEPTH_W'(MAX_DEPTH);

   logic [ssr_pkg::REQ_W-1:0]    op_ff, op_in;
   logic [SYMBOL_BITS-1:0]       sym_ff, sym_in;
   logic [CNT_W-1:0]             total_ff, total_in;
   logic [FRAME_W-1:0]           top_ff, top_in;
   logic [CNT_W-1:0]             base_ff, base_in;
   logic [DEPTH_W-1:0]           depth_ff, depth_in;
   logic [CNT_W-1:0]             gend_ff, gend_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic [CNT_W-1:0]             lo_ff, lo_in;
   logic [ADDR_W-1:0]            pos_ff, pos_in;
   logic                         scan_on_ff, scan_on_in;
   logic                         chk_ff, chk_in;
   logic                         glob_ff, glob_in;
   logic                         trim_on_ff, trim_on_in;
   logic                         trim_chk_ff, trim_chk_in;
   logic                         hit_loc_ff, hit_loc_in;
   logic                         hit_glb_ff, hit_glb_in;
   logic [ssr_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                         here_ff, here_in;
   logic [ssr_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [ssr_pkg::STATUS_W-1:0] status_ff, status_in;

   logic                         ent_we;
   logic [ADDR_W-1:0]            ent_raddr;
   logic [ENTRY_W-1:0]           ent_rdata;
   logic [SYMBOL_BITS-1:0]       ent_sym;
   logic [DEPTH_W-1:0]           ent_depth;
   logic                         frm_we;
   logic [FREC_W-1:0]            frm_rdata;
   logic [CNT_W-1:0]             total_dec;
   logic [CNT_W-1:0]             idx_dec;

   assign total_dec = total_ff - 1'b1;
   assign idx_dec   = idx_ff - 1'b1;
   assign ent_raddr = trim_on_ff ? total_dec[ADDR_W-1:0] : idx_dec[ADDR_W-1:0];
   assign ent_sym   = ent_rdata[SYMBOL_BITS-1:0];
   assign ent_depth = ent_rdata[ENTRY_W-1:SYMBOL_BITS];

   ssr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (total_ff[ADDR_W-1:0]),
      .wdata ({depth_ff, sym_ff}),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   ssr_ram #(
      .WIDTH (FREC_W),
      .DEPTH (FRAMES)
   ) u_frame_ram (
      .clock (clock),
      .we    (frm_we),
      .waddr (top_ff),
      .wdata ({base_ff, depth_ff}),
      .raddr (top_ff - 1'b1),
      .rdata (frm_rdata)
   );

   always_comb begin
      op_in       = op_ff;
      sym_in      = sym_ff;
      total_in    = total_ff;
      top_in      = top_ff;
      base_in     = base_ff;
      depth_in    = depth_ff;
      gend_in     = gend_ff;
      idx_in      = idx_ff;
      lo_in       = lo_ff;
      pos_in      = pos_ff;
      scan_on_in  = scan_on_ff;
      chk_in      = 1'b0;
      glob_in     = glob_ff;
      trim_on_in  = trim_on_ff;
      trim_chk_in = 1'b0;
      hit_loc_in  = hit_loc_ff;
      hit_glb_in  = hit_glb_ff;
      slot_in     = slot_ff;
      here_in     = here_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      ent_we      = 1'b0;
      frm_we      = 1'b0;

      if (cmd.latch) begin
         op_in     = req_type;
         sym_in    = req_symbol_key;
         status_in = ssr_pkg::STAT_OK;
      end
      if (cmd.set_status) status_in = cmd.status_code;
      if (cmd.open_scope) depth_in = depth_ff + 1'b1;
      if (cmd.push_frame) begin
         frm_we   = 1'b1;
         top_in   = top_ff + 1'b1;
         if (top_ff == '0) gend_in = total_ff;
         base_in  = total_ff;
         depth_in = '0;
      end
      if (cmd.pop_frame) begin
         total_in = base_ff;
         top_in   = top_ff - 1'b1;
      end
      if (cmd.pop_load) begin
         base_in  = frm_rdata[FREC_W-1:DEPTH_W];
         depth_in = frm_rdata[DEPTH_W-1:0];
      end
      if (cmd.add_write) begin
         ent_we   = 1'b1;
         total_in = total_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end

      // Trim walks back from the end of the frame, alternating an address issue and a depth check per entry.
      if (cmd.trim_start) begin
         trim_on_in = 1'b1;
      end else if (trim_on_ff) begin
         if (trim_chk_ff) begin
            if (ent_depth == depth_ff) begin
               total_in = total_dec;
            end else begin
               trim_on_in = 1'b0;
               depth_in   = depth_ff - 1'b1;
            end
         end else if (total_ff > base_ff) begin
            trim_chk_in = 1'b1;
         end else begin
            trim_on_in = 1'b0;
            depth_in   = depth_ff - 1'b1;
         end
      end

      // Scan issue: one address per cycle from the newest entry downward.
      if (scan_on_ff) begin
         if (idx_ff > lo_ff) begin
            idx_in = idx_dec;
            pos_in = idx_dec[ADDR_W-1:0];
            chk_in = 1'b1;
         end else begin
            scan_on_in = 1'b0;
         end
      end

      // Scan check: the entry read in the previous cycle.
      if (chk_ff) begin
         if (!glob_ff && ent_depth == depth_ff) begin
            count_in = count_ff + 1'b1;
            if (ent_sym == sym_ff) here_in = 1'b1;
         end
         if (ent_sym == sym_ff && !hit_loc_ff && !hit_glb_ff) begin
            if (glob_ff) hit_glb_in = 1'b1;
            else         hit_loc_in = 1'b1;
            slot_in = ssr_pkg::SLOT_W'(CNT_W'(pos_ff) - lo_ff);
         end
      end

      // Scan start sees the frame as this cycle's commands leave it.
      if (cmd.scan_start) begin
         scan_on_in = 1'b1;
         glob_in    = cmd.scan_global;
         if (cmd.scan_global) begin
            lo_in  = '0;
            idx_in = gend_ff;
         end else begin
            lo_in      = base_in;
            idx_in     = total_in;
            here_in    = 1'b0;
            count_in   = '0;
            hit_loc_in = 1'b0;
            hit_glb_in = 1'b0;
            slot_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         top_ff      <= '0;
         base_ff     <= '0;
         depth_ff    <= '0;
         gend_ff     <= '0;
         scan_on_ff  <= 1'b0;
         chk_ff      <= 1'b0;
         trim_on_ff  <= 1'b0;
         trim_chk_ff <= 1'b0;
      end else begin
         total_ff    <= total_in;
         top_ff      <= top_in;
         base_ff     <= base_in;
         depth_ff    <= depth_in;
         gend_ff     <= gend_in;
         scan_on_ff  <= scan_on_in;
         chk_ff      <= chk_in;
         trim_on_ff  <= trim_on_in;
         trim_chk_ff <= trim_chk_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      sym_ff     <= sym_in;
      idx_ff     <= idx_in;
      lo_ff      <= lo_in;
      pos_ff     <= pos_in;
      glob_ff    <= glob_in;
      hit_loc_ff <= hit_loc_in;
      hit_glb_ff <= hit_glb_in;
      slot_ff    <= slot_in;
      here_ff    <= here_in;
      count_ff   <= count_in;
      status_ff  <= status_in;
   end

   always_comb begin
      stat.op         = op_ff;
      stat.depth_max  = (depth_ff >= DEPTH_LIM);
      stat.depth_zero = (depth_ff == '0);
      stat.store_full = (total_ff == ENTRIES_C);
      stat.stack_full = (top_ff == FRAME_LAST);
      stat.top_zero   = (top_ff == '0);
      stat.scan_done  = !scan_on_ff && !chk_ff;
      stat.trim_done  = !trim_on_ff;
      stat.local_hit  = hit_loc_ff;
   end

   logic is_lookup;
   assign is_lookup            = (op_ff == ssr_pkg::OP_LOOKUP);
   assign rsp_found            = is_lookup && (hit_loc_ff || hit_glb_ff);
   assign rsp_is_local         = is_lookup && hit_loc_ff;
   assign rsp_slot_index       = rsp_found ? slot_ff : '0;
   assign rsp_in_current_scope = here_ff && (is_lookup || op_ff == ssr_pkg::OP_ADD);
   assign rsp_scope_count      = count_ff;
   assign rsp_status           = status_ff;

endmodule

@@ hw/rtl/ssr_checker.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol slot resolver checker
// Port-level checks of the request and result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "scoped_symbol_slot_resolver_assert.svh"

module ssr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic                         rsp_found,
   input logic                         rsp_is_local,
   input logic [ssr_pkg::SLOT_W-1:0]   rsp_slot_index,
   input logic [ssr_pkg::STATUS_W-1:0] rsp_status
);

   // An accepted beat makes the block busy right after acceptance.
   `SSR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A result only ends a request and frees the block right after.
   `SSR_ASSERT_IMPLY(a_rsp_busy, clock, reset, rsp_valid, busy)
   `SSR_ASSERT_NEXT(a_rsp_free, clock, reset, rsp_valid, !busy && !rsp_valid)
   // A miss carries no slot and no locality.
   `SSR_ASSERT_IMPLY(a_miss_clean, clock, reset, rsp_valid && !rsp_found,
                     rsp_slot_index == '0 && !rsp_is_local)
   // A failed request never reports a hit.
   `SSR_ASSERT_IMPLY(a_err_nohit, clock, reset, rsp_valid && rsp_status != ssr_pkg::STAT_OK,
                     !rsp_found)

endmodule

bind scoped_symbol_slot_resolver ssr_checker u_ssr_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_found      (rsp_found),
   .rsp_is_local   (rsp_is_local),
   .rsp_slot_index (rsp_slot_index),
   .rsp_status     (rsp_status)
);
